### src/sd64_pkg.sv
package sd64_pkg;

   localparam int DividendBits = 64;
   localparam int DivisorField = 32;
   localparam int QuotientBits = 32;
   // Width of the divisor actually used and of the quotient produced (8..32)
   localparam int DivisorBits  = 32;
   localparam int HighBits     = DividendBits - DivisorBits;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_DIVZERO  = 2'd2
   } status_type;

   typedef struct packed {
      logic [DividendBits-1:0] dividend;
      logic [DivisorField-1:0] divisor;
   } req_type;

   typedef struct packed {
      logic [QuotientBits-1:0] quotient;
      status_type              status;
   } rsp_type;

   // Partial state of one division between pipeline stages.
   // lq holds the unconsumed dividend bits on top and quotient bits below.
   typedef struct packed {
      logic [DivisorBits-1:0] rem;
      logic [DivisorBits-1:0] lq;
      logic [DivisorBits-1:0] den;
      status_type             status;
   } step_type;

endpackage

### src/sd64_step.sv
module sd64_step
   import sd64_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  step_type in_data,
   output logic     up_ready,
   output logic     out_valid,
   output step_type out_data,
   input  logic     down_ready
);

   logic                 valid_ff, valid_in;
   step_type             data_ff, data_in;
   logic [DivisorBits:0] trial;
   logic [DivisorBits:0] den_ext;
   logic [DivisorBits:0] diff;
   logic                 ge;

   // Bring down the next dividend bit and try a subtract.
   always_comb begin
      trial   = {in_data.rem, in_data.lq[DivisorBits-1]};
      den_ext = {1'b0, in_data.den};
      diff    = trial - den_ext;
      ge      = (trial >= den_ext);
      data_in        = in_data;
      data_in.rem    = ge ? diff[DivisorBits-1:0] : trial[DivisorBits-1:0];
      data_in.lq     = {in_data.lq[DivisorBits-2:0], ge};
   end

   // Accept when empty or when the held item moves on.
   assign up_ready = !valid_ff || down_ready;
   assign valid_in = up_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### src/saturating_divide_64_by_32_top.sv
// Throughput: one division per cycle while rsp_ready is high; one entry stage for range
// checks, then one restoring subtract-and-compare step per pipeline stage.
// Stages with a free slot keep accepting while a finished result waits on rsp_ready.
// Reset (synchronous, active high) clears every stage valid bit; data registers keep
// their contents.
module saturating_divide_64_by_32_top
   import sd64_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Stage 0 is the entry register, stages 1..DivisorBits do one quotient bit each.
   logic     stage_valid [DivisorBits+1];
   step_type stage_data  [DivisorBits+1];
   // ready[k]: stage k can take an item this cycle; the last slot is the consumer.
   logic     ready       [DivisorBits+2];

   // ---------------------------------------------------------------------------
   // Entry stage: mask the divisor, flag divide by zero and overflow.
   // ---------------------------------------------------------------------------
   logic                   entry_valid_ff, entry_valid_in;
   step_type               entry_ff, entry_in;
   logic [DivisorBits-1:0] den;
   logic [HighBits-1:0]    high;

   always_comb begin
      den  = req_data.divisor[DivisorBits-1:0];
      high = req_data.dividend[DividendBits-1:DivisorBits];
      entry_in.den = den;
      // Only meaningful when the high part is below the divisor.
      entry_in.rem = high[DivisorBits-1:0];
      entry_in.lq  = req_data.dividend[DivisorBits-1:0];
      // Zero divisor wins over overflow.
      priority if (den == '0) begin
         entry_in.status = ST_DIVZERO;
      end else if (high >= HighBits'(den)) begin
         entry_in.status = ST_OVERFLOW;
      end else begin
         entry_in.status = ST_OK;
      end
   end

   assign ready[0]       = !entry_valid_ff || ready[1];
   assign req_ready      = ready[0];
   assign entry_valid_in = ready[0] ? req_valid : entry_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   // Load a new operand pair on every transfer.
   always_ff @(posedge clock) begin
      if (req_valid && ready[0]) begin
         entry_ff <= entry_in;
      end
   end

   assign stage_valid[0] = entry_valid_ff;
   assign stage_data[0]  = entry_ff;

   // ---------------------------------------------------------------------------
   // Restoring division steps, one quotient bit per stage, MSB first.
   // ---------------------------------------------------------------------------
   genvar k;
   generate
      for (k = 1; k <= DivisorBits; k++) begin : g_step
         sd64_step u_step (
            .clock      (clock),
            .reset      (reset),
            .in_valid   (stage_valid[k-1]),
            .in_data    (stage_data[k-1]),
            .up_ready   (ready[k]),
            .out_valid  (stage_valid[k]),
            .out_data   (stage_data[k]),
            .down_ready (ready[k+1])
         );
      end
   endgenerate

   assign ready[DivisorBits+1] = rsp_ready;

   // ---------------------------------------------------------------------------
   // Result: the last step register is the output register.
   // ---------------------------------------------------------------------------
   step_type last;
   assign last      = stage_data[DivisorBits];
   assign rsp_valid = stage_valid[DivisorBits];

   always_comb begin
      rsp_data.status = last.status;
      unique case (last.status)
         ST_OK:       rsp_data.quotient = QuotientBits'(last.lq);
         ST_OVERFLOW: rsp_data.quotient = QuotientBits'({DivisorBits{1'b1}});
         ST_DIVZERO:  rsp_data.quotient = '0;
         default:     rsp_data.quotient = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------

   // A zero divisor must reach the entry register flagged as divide by zero.
   a_divzero_entry : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.divisor[DivisorBits-1:0] == '0)
      |=> (entry_valid_ff && entry_ff.status == ST_DIVZERO))
      else $error("divide by zero not flagged at entry");

   // A stalled entry item must stay in place.
   a_entry_hold : assert property (@(posedge clock) disable iff (reset)
      (entry_valid_ff && !ready[1]) |=> (entry_valid_ff && $stable(entry_ff)))
      else $error("entry stage item lost or changed during stall");

   // A completed in-range division leaves a remainder below the divisor.
   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && last.status == ST_OK) |-> (last.rem < last.den))
      else $error("remainder not below divisor at output");

endmodule

### tb/tb_saturating_divide_64_by_32_top.sv
module tb_saturating_divide_64_by_32_top;
   import sd64_pkg::*;

   // Operand pair waiting to be offered, with an optional hold until the pipe is empty
   typedef struct {
      req_type operands;
      bit      drain_first;
   } operand_entry;

   localparam int NumRandom = 500;
   localparam int DrainCycles = DivisorBits + 10;
   localparam logic [63:0] WidthMask = (64'd1 << DivisorBits) - 64'd1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   operand_entry pending_operands[$];
   rsp_type      expected_quotients[$];
   int           error_count = 0;
   int           transfers_in = 0;
   int           results_seen = 0;
   int           hold_off_left = 0;
   bit           hold_off_done = 1'b0;

   saturating_divide_64_by_32_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Compute the expected quotient and status for one operand pair.
   function automatic rsp_type predict_quotient(req_type op);
      logic [63:0] den;
      logic [63:0] full_quotient;
      rsp_type     r;
      den = {32'd0, op.divisor} & WidthMask;
      if (den == 64'd0) begin
         // Divide by zero wins over overflow
         r.quotient = '0;
         r.status   = ST_DIVZERO;
      end else if ((op.dividend >> DivisorBits) >= den) begin
         // Quotient needs more than DivisorBits bits: saturate
         r.quotient = WidthMask[QuotientBits-1:0];
         r.status   = ST_OVERFLOW;
      end else begin
         full_quotient = op.dividend / den;
         r.quotient    = full_quotient[QuotientBits-1:0];
         r.status      = ST_OK;
      end
      return r;
   endfunction

   task automatic queue_operands(logic [63:0] dividend, logic [31:0] divisor, bit drain_first);
      operand_entry e;
      e.operands.dividend = dividend;
      e.operands.divisor  = divisor;
      e.drain_first       = drain_first;
      pending_operands.push_back(e);
   endtask

   // Build one random operand pair, biased toward the interesting regions.
   task automatic queue_random_operands(bit drain_first);
      logic [31:0] divisor;
      logic [63:0] den;
      logic [63:0] high_part;
      logic [63:0] low_part;
      logic [63:0] dividend;
      int          kind;
      kind      = $urandom_range(9);
      divisor   = $urandom;
      low_part  = {$urandom, $urandom} & WidthMask;
      if (kind == 3) begin
         // Keep only a few low bits, but let bits above the used width wander
         divisor = (divisor & ~WidthMask[31:0]) | 32'($urandom_range(255));
      end
      if (kind != 0 && (divisor & WidthMask[31:0]) == 32'd0) begin
         divisor = divisor | 32'd1;
      end
      den = {32'd0, divisor} & WidthMask;
      case (kind)
         0: begin
            // Zero divisor in the used bits, random dividend
            divisor  = divisor & ~WidthMask[31:0];
            dividend = {$urandom, $urandom};
         end
         1: begin
            // High part at or above the divisor: overflow
            high_part = 64'($urandom_range(WidthMask[31:0], den[31:0]));
            dividend  = (high_part << DivisorBits) | low_part;
         end
         2: begin
            // Straddle the overflow boundary
            if ($urandom_range(1) == 1) begin
               dividend = (den << DivisorBits) - 64'd1;
            end else begin
               dividend = den << DivisorBits;
            end
         end
         9: begin
            dividend = {$urandom, $urandom};
         end
         default: begin
            // Quotient fits: exercise the long division itself
            high_part = 64'($urandom_range(den[31:0] - 32'd1));
            dividend  = (high_part << DivisorBits) | low_part;
         end
      endcase
      queue_operands(dividend, divisor, drain_first);
   endtask

   // Driver: offer operand pairs, hold them until the transfer, insert random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_quotients.push_back(predict_quotient(req_data));
            pending_operands.delete(0);
            transfers_in = transfers_in + 1;
         end
         if (!(req_valid && !req_ready)) begin
            // Drop valid on an empty queue, a drain marker with work in flight, or a gap;
            // keep a long stretch with no gaps at all
            if (pending_operands.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_operands[0].drain_first && expected_quotients.size() != 0) begin
               req_valid <= 1'b0;
            end else if (!(transfers_in >= 250 && transfers_in < 380)
                         && $urandom_range(99) < 21) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data  <= pending_operands[0].operands;
            end
         end
      end
   end

   // Monitor: check every result transfer against the oldest prediction and
   // drive rsp_ready with random stalls plus one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen = results_seen + 1;
            if (expected_quotients.size() == 0) begin
               $display("%0t: unexpected result quotient=%h status=%0d",
                        $time, rsp_data.quotient, rsp_data.status);
               error_count = error_count + 1;
            end else begin
               if (rsp_data.quotient !== expected_quotients[0].quotient) begin
                  $display("%0t: quotient mismatch expected=%h actual=%h", $time,
                           expected_quotients[0].quotient, rsp_data.quotient);
                  error_count = error_count + 1;
               end
               if (rsp_data.status !== expected_quotients[0].status) begin
                  $display("%0t: status mismatch expected=%0d actual=%0d", $time,
                           expected_quotients[0].status, rsp_data.status);
                  error_count = error_count + 1;
               end
               expected_quotients.delete(0);
            end
         end
         if (!hold_off_done && results_seen >= 60) begin
            // Hold off long enough for the pipeline to fill and stall the input
            hold_off_done = 1'b1;
            hold_off_left = 150;
         end
         if (hold_off_left > 0) begin
            hold_off_left = hold_off_left - 1;
            rsp_ready <= 1'b0;
         end else if (results_seen >= 300 && results_seen < 420) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 21);
         end
      end
   end

   initial begin
      int i;
      // Directed corners
      queue_operands(64'd0, 32'd1, 1'b0);
      queue_operands(64'd100, 32'd7, 1'b0);
      queue_operands(64'd6, 32'd7, 1'b0);
      queue_operands(64'd0, 32'd0, 1'b0);
      queue_operands(64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0);
      queue_operands(64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 1'b0);
      queue_operands(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      queue_operands(64'hFFFF_FFFE_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      queue_operands(64'h0000_0000_FFFF_FFFF, 32'd1, 1'b0);
      queue_operands(64'h0000_0001_0000_0000, 32'd1, 1'b0);
      queue_operands(64'h8000_0000_0000_0000, 32'h8000_0000, 1'b0);
      queue_operands(64'h7FFF_FFFF_FFFF_FFFF, 32'h8000_0000, 1'b0);
      queue_operands(64'h1234_5677_FFFF_FFFF, 32'h1234_5678, 1'b0);
      queue_operands(64'h1234_5678_0000_0000, 32'h1234_5678, 1'b0);
      queue_operands(64'h0000_0000_0000_0001, 32'hFFFF_FFFF, 1'b0);
      queue_operands(64'hAAAA_AAAA_5555_5555, 32'hFFFF_FF00, 1'b0);
      queue_operands(64'h5555_5555_AAAA_AAAA, 32'hAAAA_AAAB, 1'b0);
      queue_operands(64'h0000_00FF_FFFF_FFFF, 32'h0000_0100, 1'b0);
      // Divisor with only bits above the used width set: zero after masking when narrow
      queue_operands(64'h0000_0000_0000_1000, 32'hFF00_0000, 1'b0);
      queue_operands(64'h0000_0000_0001_0000, 32'hFFFF_FF01, 1'b0);
      for (i = 0; i < NumRandom; i++) begin
         queue_random_operands(i % 125 == 0);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait for every transfer in, then every result out, then let the pipe drain
      while (pending_operands.size() != 0 || req_valid) @(posedge clock);
      while (expected_quotients.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
src/sd64_pkg.sv
src/sd64_step.sv
src/saturating_divide_64_by_32_top.sv
tb/tb_saturating_divide_64_by_32_top.sv
